// File: sv/lrupr_pkg.sv
package lrupr_pkg;

  // Widths sized for the largest build (64 frames, 32-bit pages).
  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = 6;   // frame index, 0..MAX_FRAMES-1
  localparam int CNT_W      = 7;   // ranks and frame counts, 0..MAX_FRAMES
  localparam int PAGE_MAX_W = 32;

  // Port field widths
  localparam int CFG_W      = 5;
  localparam int IN_PAGE_W  = 20;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_IDX_W  = 4;
  localparam int OUT_PAGE_W = 20;
  localparam int FAULT_W    = 32;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - (1 + OUT_IDX_W + 1 + OUT_PAGE_W + FAULT_W);

  // Partial search result, passed from cell to cell.
  typedef struct packed {
    logic                  vld;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [CNT_W-1:0]      hit_rank;
    logic                  empty;
    logic [IDX_W-1:0]      empty_idx;
    logic [CNT_W-1:0]      best_rank;
    logic [IDX_W-1:0]      best_idx;
    logic [PAGE_MAX_W-1:0] best_page;
  } lrupr_acc_t;

  // Broadcast update applied to all cells at commit.
  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      idx;
    logic [CNT_W-1:0]      old_rank;
    logic                  wr_page;
    logic [PAGE_MAX_W-1:0] page;
  } lrupr_upd_t;

endpackage

// File: sv/lru_page_replacement_top.sv
// One reference at a time: in_tready is high only in idle. The request walks the cell
//   row one frame per cycle, the result is held in the done state, then a commit updates
//   all frames and loads the output, and the block is back in idle for the next transfer.
//   A commit waits while the previous result is still unread.
// Reset (rst_n low at a clock edge): all frames empty, ranks and fault count zero,
//   active frame count back to 16 (limited to FRAMES). Page storage is not cleared.
module lru_page_replacement_top
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 16,   // 1..64
  parameter int PAGE_BITS = 20    // 1..32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // reference input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [19:0] page_number, [23:20] zero
  // result output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] hit, [4:1] frame_index,
                                            // [5] evicted_valid, [25:6] evicted_page,
                                            // [57:26] fault_count, [63:58] zero
  // active_frames register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int ACT_RST = (FRAMES < 16) ? FRAMES : 16;

  // Control: idle, request walking the cells, result waiting to commit.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   start_r;
  logic [PAGE_BITS-1:0]   req_page_r;
  logic [CNT_W-1:0]       act_r, act_nxt;
  logic [FAULT_W-1:0]     faults_r, faults_nxt;
  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;

  lrupr_acc_t             chain [FRAMES+1];
  lrupr_acc_t             res;
  lrupr_upd_t             upd;
  logic [FRAMES:0]        vld_vec;

  logic                   in_xfer;
  logic                   commit;
  logic [IDX_W-1:0]       f_idx;
  logic                   ev_valid;
  logic [PAGE_MAX_W-1:0]  ev_page;

  assign in_tready = state_r == ST_IDLE;
  assign cfg_ready = state_r == ST_IDLE;
  assign in_xfer   = in_tvalid && in_tready;

  // --------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------
  assign res    = chain[FRAMES];
  assign commit = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer)   state_nxt = ST_SCAN;
      ST_SCAN: if (res.vld)   state_nxt = ST_DONE;
      ST_DONE: if (commit)    state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_xfer;
    end
  end

  // page taken modulo 2^PAGE_BITS
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_page_r <= PAGE_BITS'(PAGE_MAX_W'(in_tdata[IN_PAGE_W-1:0]));
    end
  end

  // --------------------------------------------------------------------
  // Active frame count: zero acts as one, too large acts as FRAMES
  // --------------------------------------------------------------------
  always_comb begin
    if (cfg_data == '0) begin
      act_nxt = CNT_W'(1);
    end else if (32'(cfg_data) > FRAMES) begin
      act_nxt = CNT_W'(FRAMES);
    end else begin
      act_nxt = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= CNT_W'(ACT_RST);
    end else if (cfg_valid && cfg_ready) begin
      act_r <= act_nxt;
    end
  end

  // --------------------------------------------------------------------
  // Cell row: each cell adds its frame to the search and passes it on
  // --------------------------------------------------------------------
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = start_r;
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .IDX       (g),
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req_page (req_page_r),
      .n_active (act_r),
      .acc_in   (chain[g]),
      .acc_out  (chain[g+1]),
      .upd      (upd)
    );
  end

  always_comb begin
    for (int i = 0; i <= FRAMES; i++) begin
      vld_vec[i] = chain[i].vld;
    end
  end

  // --------------------------------------------------------------------
  // Commit: pick the frame, broadcast the recency update, load output
  // Hit keeps its frame; miss fills the first empty frame, else the oldest.
  // --------------------------------------------------------------------
  always_comb begin
    ev_valid = 1'b0;
    ev_page  = '0;
    upd.en   = commit;
    upd.page = PAGE_MAX_W'(req_page_r);
    if (res.hit) begin
      f_idx        = res.hit_idx;
      upd.old_rank = res.hit_rank;
      upd.wr_page  = 1'b0;
    end else if (res.empty) begin
      f_idx        = res.empty_idx;
      upd.old_rank = CNT_W'(FRAMES);   // empty frame is older than all
      upd.wr_page  = 1'b1;
    end else begin
      f_idx        = res.best_idx;
      upd.old_rank = res.best_rank;
      upd.wr_page  = 1'b1;
      ev_valid     = 1'b1;
      ev_page      = res.best_page;
    end
    upd.idx = f_idx;
  end

  // saturating fault count
  always_comb begin
    faults_nxt = faults_r;
    if (!res.hit && (faults_r != '1)) begin
      faults_nxt = faults_r + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      faults_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (commit) begin
        faults_r     <= faults_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_tdata_r <= {OUT_PAD_W'(0), faults_nxt, ev_page[OUT_PAGE_W-1:0], ev_valid,
                      f_idx[OUT_IDX_W-1:0], res.hit};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------
  // only one search in flight along the cell row
  a_one_search: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_vec))
    else $error("more than one search in the cell row");

  // search reaches the end of the row only while scanning
  a_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (state_r == ST_SCAN))
    else $error("search finished outside scan");

  // end of search moves to commit wait
  a_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |=> (state_r == ST_DONE))
    else $error("finished search not held for commit");

  // fault count changes only at a commit
  a_fault_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(faults_r))
    else $error("fault count changed without commit");

  // no new reference while a search is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || res.vld || commit) |-> !in_xfer)
    else $error("reference accepted while busy");

endmodule

// File: sv/lrupr_cell.sv
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PAGE_BITS-1:0] req_page,
  input  logic [CNT_W-1:0]     n_active,
  input  lrupr_acc_t           acc_in,
  output lrupr_acc_t           acc_out,
  input  lrupr_upd_t           upd
);

  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [RW-1:0]        rank_r;
  lrupr_acc_t           acc_r;
  lrupr_acc_t           acc_nxt;

  logic             active;
  logic [CNT_W-1:0] rank_ext;
  logic             is_target;

  assign active    = n_active > CNT_W'(IDX);
  assign rank_ext  = CNT_W'(rank_r);
  assign is_target = upd.idx == IDX_W'(IDX);

  // fold this frame into the running search
  always_comb begin
    acc_nxt = acc_in;
    if (active) begin
      if (!acc_in.hit && valid_r && (page_r == req_page)) begin
        acc_nxt.hit      = 1'b1;
        acc_nxt.hit_idx  = IDX_W'(IDX);
        acc_nxt.hit_rank = rank_ext;
      end
      if (!acc_in.empty && !valid_r) begin
        acc_nxt.empty     = 1'b1;
        acc_nxt.empty_idx = IDX_W'(IDX);
      end
      // frame 0 seeds the oldest-frame search
      if ((IDX == 0) || (rank_ext > acc_in.best_rank)) begin
        acc_nxt.best_rank = rank_ext;
        acc_nxt.best_idx  = IDX_W'(IDX);
        acc_nxt.best_page = PAGE_MAX_W'(page_r);
      end
    end
  end

  // payload held after the valid bit drops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r.vld <= 1'b0;
    end else if (acc_in.vld) begin
      acc_r <= acc_nxt;
    end else begin
      acc_r.vld <= 1'b0;
    end
  end

  assign acc_out = acc_r;

  // recency update: target becomes newest, younger valid frames age
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd.en) begin
      if (is_target) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (valid_r && (rank_ext < upd.old_rank)) begin
        rank_r <= rank_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && is_target && upd.wr_page) begin
      page_r <= upd.page[PAGE_BITS-1:0];
    end
  end

endmodule

// File: bench/tb_lru_page_replacement_top.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement_top;
  import lrupr_pkg::*;

  localparam int N_FRAMES    = 16;        // frame count of the default build
  localparam int CYCLE_LIMIT = 500_000;   // watchdog; slowest clean run is far below
  localparam int PAGE_SPAN   = (1 << IN_PAGE_W) - 1;
  localparam logic [IN_PAGE_W-1:0] PAGE_ONES = '1;
  localparam int N_PHASES    = 10;
  localparam int PHASE_REFS  = 135;

  // Result fields, packed so that hit lands in bit 0 of out_tdata.
  typedef struct packed {
    logic [OUT_PAD_W-1:0]  pad;
    logic [FAULT_W-1:0]    fault_count;
    logic [OUT_PAGE_W-1:0] evicted_page;
    logic                  evicted_valid;
    logic [OUT_IDX_W-1:0]  frame_index;
    logic                  hit;
  } lookup_t;

  // Shadow copy of the frame table: predicts each lookup and checks the
  // results in order of arrival.
  class lru_frame_tracker_t;
    logic [IN_PAGE_W-1:0] page_of [N_FRAMES];
    bit                   valid_of[N_FRAMES];
    int unsigned          rank_of [N_FRAMES];
    logic [FAULT_W-1:0]   faults;
    int unsigned          active;
    lookup_t              pending_lookups[$];
    int unsigned          errors;

    function void clear();
      for (int i = 0; i < N_FRAMES; i++) begin
        page_of[i]  = '0;
        valid_of[i] = 1'b0;
        rank_of[i]  = 0;
      end
      faults = '0;
      active = N_FRAMES;
      pending_lookups.delete();
      errors = 0;
    endfunction

    // zero acts as one, anything past the build acts as the full table
    function void write_active(logic [CFG_W-1:0] v);
      if (v == 0)
        active = 1;
      else if (v > N_FRAMES)
        active = N_FRAMES;
      else
        active = 32'(v);
    endfunction

    function void predict_lookup(logic [IN_PAGE_W-1:0] pg);
      lookup_t     r;
      int          f;
      int unsigned best;
      int unsigned old;
      bit          found;
      bit          empty;
      r     = '0;
      f     = 0;
      found = 1'b0;
      empty = 1'b0;
      // lowest-numbered active match wins, so duplicates resolve low
      for (int i = 0; i < active && !found; i++)
        if (valid_of[i] && page_of[i] == pg) begin
          f     = i;
          found = 1'b1;
        end
      if (found) begin
        r.hit = 1'b1;
      end else begin
        if (faults != '1)
          faults = faults + FAULT_W'(1);
        for (int i = 0; i < active && !empty; i++)
          if (!valid_of[i]) begin
            f     = i;
            empty = 1'b1;
          end
        // table full: replace the oldest active frame
        if (!empty) begin
          best = 0;
          f    = 0;
          for (int i = 0; i < active; i++)
            if (rank_of[i] > best) begin
              best = rank_of[i];
              f    = i;
            end
          r.evicted_valid = 1'b1;
          r.evicted_page  = page_of[f];
        end
        page_of[f] = pg;
      end
      // age everything younger than f (inactive frames too); empty f counts as oldest
      old = valid_of[f] ? rank_of[f] : N_FRAMES;
      for (int i = 0; i < N_FRAMES; i++)
        if (i != f && valid_of[i] && rank_of[i] < old)
          rank_of[i]++;
      rank_of[f]    = 0;
      valid_of[f]   = 1'b1;
      r.frame_index = OUT_IDX_W'(f);
      r.fault_count = faults;
      pending_lookups.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_lookup(logic [OUT_DATA_W-1:0] d);
      lookup_t got;
      lookup_t want;
      got = lookup_t'(d);
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, d);
        errors++;
        return;
      end
      want = pending_lookups.pop_front();
      compare_field("hit",           64'(want.hit),           64'(got.hit));
      compare_field("frame_index",   64'(want.frame_index),   64'(got.frame_index));
      compare_field("evicted_valid", 64'(want.evicted_valid), 64'(got.evicted_valid));
      compare_field("evicted_page",  64'(want.evicted_page),  64'(got.evicted_page));
      compare_field("fault_count",   64'(want.fault_count),   64'(got.fault_count));
      compare_field("pad",           64'(want.pad),           64'(got.pad));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [19:0] page_number, [23:20] zero
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] hit, [4:1] frame_index, [5] evicted_valid,
                                     // [25:6] evicted_page, [57:26] fault_count, [63:58] zero
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  lru_frame_tracker_t book;
  int unsigned      tx_idle;       // percent of cycles the sender holds off
  int unsigned      rx_idle;       // percent of cycles out_tready is low
  int unsigned      cycle_count;

  lru_page_replacement_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_lru_page_replacement_top: done, errors");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  // Transfer monitor. Values read here are the ones sampled at the edge;
  // everything in the bench and the block changes through NBAs.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        book.predict_lookup(in_tdata[IN_PAGE_W-1:0]);
      if (out_tvalid && out_tready)
        book.check_lookup(out_tdata);
    end
  end

  // waits for the monitor to log the last input transfer before checking the queue
  task automatic wait_drained();
    @(posedge clk);
    while (book.pending_lookups.size() != 0)
      @(posedge clk);
  endtask

  // Register write only once all lookups are back, i.e. the block is idle.
  task automatic write_cfg(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.write_active(v);
  endtask

  // Holds in_tvalid high after the transfer; caller drops it at the end of a batch.
  task automatic send_page(input logic [IN_PAGE_W-1:0] pg);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-IN_PAGE_W){1'b0}}, pg};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [CFG_W-1:0]     phase_cfg[N_PHASES];
    logic [IN_PAGE_W-1:0] working_set[$];
    logic [IN_PAGE_W-1:0] pg;
    int                   ws_size;

    book = new();
    book.clear();
    phase_cfg = '{5'd17, 5'd1, 5'd16, 5'd4, 5'd31, 5'd8, 5'd0, 5'd12, 5'd2, 5'd16};
    tx_idle    = 10;
    rx_idle    = 64;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: three frames, fill, hit, evict the oldest
    write_cfg(5'd3);
    send_page('0);
    send_page(PAGE_ONES);
    send_page('0);
    send_page(20'h12345);
    send_page(20'h54321);
    in_tvalid <= 1'b0;
    // zero written acts as a single frame
    write_cfg(5'd0);
    send_page(20'hAAAAA);
    send_page(PAGE_ONES);
    in_tvalid <= 1'b0;
    // above the build acts as all frames; inactive frames kept their pages,
    // and an empty frame is filled while resident pages remain
    write_cfg(5'd31);
    send_page(20'h12345);
    send_page(20'h00001);
    in_tvalid <= 1'b0;
    // shrink: frame 2 is out of view, so its page faults into frame 0 or 1
    write_cfg(5'd2);
    send_page(20'h12345);
    in_tvalid <= 1'b0;
    // grow back: two copies now, lowest match must win
    write_cfg(5'd16);
    send_page(20'h12345);
    send_page(20'h55555);
    send_page('0);
    in_tvalid <= 1'b0;

    // Random phases: mostly a working set sized near the active frame count,
    // so hits, fills and evictions all happen; the rest is full-range noise.
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 4) begin
        tx_idle = 10;
        rx_idle = 64;
      end else if (p < 7) begin
        tx_idle = 64;
        rx_idle = 10;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      write_cfg(phase_cfg[p]);
      working_set.delete();
      ws_size = $urandom_range(1, book.active + 6);
      repeat (ws_size) working_set.push_back(IN_PAGE_W'($urandom_range(0, PAGE_SPAN)));
      repeat (PHASE_REFS) begin
        if ($urandom_range(99) < 85)
          pg = working_set[$urandom_range(0, working_set.size() - 1)];
        else
          pg = IN_PAGE_W'($urandom_range(0, PAGE_SPAN));
        // slow drift of the working set
        if ($urandom_range(99) < 3)
          working_set[$urandom_range(0, working_set.size() - 1)] =
            IN_PAGE_W'($urandom_range(0, PAGE_SPAN));
        send_page(pg);
      end
      in_tvalid <= 1'b0;
    end

    wait_drained();
    // a stray extra result would show up within one pass of the cell row
    repeat (2 * N_FRAMES + 4) @(posedge clk);
    if (book.errors == 0)
      $display("tb_lru_page_replacement_top: done, clean");
    else
      $display("tb_lru_page_replacement_top: done, errors");
    $finish;
  end

endmodule
